### rtl/clcd_pkg.sv
// Package: payload types, mode codes and command tables of the LCD nibble writer.
package clcd_pkg;

  localparam int VALUE_W    = 32;
  localparam int BITCNT_W   = 5;
  localparam int INT_DIGITS = 10;
  localparam int INIT_LEN   = 7;

  localparam logic [2:0] MODE_DATA   = 3'd0;
  localparam logic [2:0] MODE_CMD    = 3'd1;
  localparam logic [2:0] MODE_CURSOR = 3'd2;
  localparam logic [2:0] MODE_INT    = 3'd3;
  localparam logic [2:0] MODE_INIT   = 3'd4;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] CURSOR_CMD = 8'h80;

  typedef struct packed {
    logic [2:0]         mode;
    logic [VALUE_W-1:0] value;
    logic [2:0]         row;
    logic [4:0]         column;
  } clcd_in_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } clcd_out_t;

  typedef struct packed {
    logic       valid;
    logic       rs;
    logic [7:0] data;
    logic       last;
  } tx_req_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h03;
      3'd1:    b = 8'h03;
      3'd2:    b = 8'h02;
      3'd3:    b = 8'h28;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h0C;
      3'd6:    b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [6:0] row_base(input logic [1:0] row);
    logic [6:0] b;
    unique case (row)
      2'd0: b = 7'h00;
      2'd1: b = 7'h40;
      2'd2: b = 7'h14;
      2'd3: b = 7'h54;
    endcase
    return b;
  endfunction

endpackage

### rtl/clcd_stream_if.sv
// Interface: valid/ready channel with a typed payload.
interface clcd_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/clcd_bin2bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module clcd_bin2bcd
  import clcd_pkg::*;
#(
  parameter int DIGITS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [VALUE_W-1:0]          value,
  output logic                        done,
  output logic [DIGITS-1:0][3:0]      digits,
  output logic [((DIGITS > 1) ? $clog2(DIGITS) : 1)-1:0] msd_idx
);

  localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic                   busy_r;
  logic                   done_r;
  logic                   ovf_r;
  logic [BITCNT_W-1:0]    bitcnt_r;
  logic [VALUE_W-1:0]     sh_r;
  logic [DIGITS-1:0][3:0] bcd_r;
  logic [DIGITS-1:0][3:0] corr;
  logic [4*DIGITS:0]      wide;
  logic [DIGITS-1:0][3:0] bcd_nxt;
  logic [IDX_W-1:0]       msd;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      corr[i] = (bcd_r[i] >= 4'd5) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
    wide    = {corr, sh_r[VALUE_W-1]};
    bcd_nxt = wide[4*DIGITS-1:0];
  end

  // digits dropped above the kept range still count as present
  always_comb begin
    msd = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) msd = IDX_W'(i);
    end
    if (ovf_r) msd = IDX_W'(DIGITS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      bitcnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        bitcnt_r <= '0;
        sh_r     <= value;
        bcd_r    <= '0;
        ovf_r    <= 1'b0;
      end else if (busy_r) begin
        sh_r     <= {sh_r[VALUE_W-2:0], 1'b0};
        bcd_r    <= bcd_nxt;
        ovf_r    <= ovf_r | wide[4*DIGITS];
        bitcnt_r <= bitcnt_r + 1'b1;
        if (bitcnt_r == BITCNT_W'(VALUE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign digits  = bcd_r;
  assign msd_idx = msd;

endmodule

### rtl/clcd_nibble_tx.sv
// Byte to nibble serializer: high nibble then low nibble, held in an output register.
module clcd_nibble_tx
  import clcd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  tx_req_t       req,
  output logic          req_ready,
  clcd_stream_if.source out_chan
);

  logic       busy_r;
  logic       half_r;
  logic       rs_r;
  logic       last_r;
  logic [7:0] data_r;

  assign req_ready = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      half_r <= 1'b0;
    end else if (!busy_r) begin
      if (req.valid) begin
        busy_r <= 1'b1;
        half_r <= 1'b0;
        rs_r   <= req.rs;
        last_r <= req.last;
        data_r <= req.data;
      end
    end else if (out_chan.ready) begin
      data_r <= {data_r[3:0], 4'h0};
      half_r <= 1'b1;
      if (half_r) busy_r <= 1'b0;
    end
  end

  assign out_chan.valid           = busy_r;
  assign out_chan.data.reg_select = rs_r;
  assign out_chan.data.nibble     = data_r[7:4];
  assign out_chan.data.last       = last_r & half_r;

endmodule

### rtl/char_lcd_nibble_write_engine.sv
// Top level: request sequencer of the character LCD nibble write engine.
//
// in_chan carries one request (mode, value, row, column); out_chan carries
// one nibble transaction per LCD bus write (reg_select, nibble, last), high
// nibble of each byte first. cfg_chan writes pad_single_digit; it is always
// ready and should only be written while no request is in flight.
// A request is taken only while the sequencer is idle. For each byte the
// nibble serializer is loaded, then sends the high and the low nibble.
// Data char, command and cursor: one byte per request. Init: 7 bytes.
// Print integer: the bit-serial BCD converter runs first, then one byte
// per emitted digit, at most 10 bytes. Unused modes and cursor positions
// out of range produce nothing and leave the block ready at once.
// A stall on out_chan holds the current nibble in the output register and
// stalls the sequencer; nothing is dropped. Reset clears the sequencer
// state, counters and busy flags (not mode_r and byte_r) and sets
// pad_single_digit to 1.
module char_lcd_nibble_write_engine
  import clcd_pkg::*;
#(
  parameter int ROWS       = 4,
  parameter int COLUMNS    = 20,
  parameter int MAX_DIGITS = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  clcd_stream_if.sink   in_chan,
  clcd_stream_if.source out_chan,
  clcd_stream_if.sink   cfg_chan
);

  localparam int DIGITS = (MAX_DIGITS < INT_DIGITS) ? MAX_DIGITS : INT_DIGITS;
  localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CNT_W  = (IDX_W > 3) ? IDX_W : 3;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

  state_t             state_r;
  logic [2:0]         mode_r;
  logic [7:0]         byte_r;
  logic               pad_r;
  logic               cfg_pad_r;
  logic [CNT_W-1:0]   cnt_r;

  clcd_in_t               item;
  logic                   accept;
  logic                   cursor_ok;
  logic [7:0]             cursor_byte;
  logic [7:0]             sum;
  logic                   conv_done;
  logic [DIGITS-1:0][3:0] digits;
  logic [IDX_W-1:0]       msd_idx;
  tx_req_t                req;
  logic                   req_ready;

  assign item           = in_chan.data;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign accept         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cursor_ok   = (32'(item.row) < ROWS) && (item.row < 3'd4)
                  && (32'(item.column) < COLUMNS);
    sum         = {1'b0, row_base(item.row[1:0])} + {3'b000, item.column};
    cursor_byte = CURSOR_CMD | {1'b0, sum[6:0]};
  end

  clcd_bin2bcd #(.DIGITS(DIGITS)) u_bcd (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept && (item.mode == MODE_INT)),
    .value   (item.value),
    .done    (conv_done),
    .digits  (digits),
    .msd_idx (msd_idx)
  );

  always_comb begin
    req.valid = (state_r == S_EMIT);
    req.rs    = 1'b0;
    req.data  = byte_r;
    req.last  = 1'b1;
    unique case (mode_r)
      MODE_DATA: req.rs = 1'b1;
      MODE_INT: begin
        req.rs = 1'b1;
        if (pad_r) begin
          req.data = ASCII_ZERO;
          req.last = 1'b0;
        end else begin
          req.data = ASCII_ZERO | {4'h0, digits[cnt_r[IDX_W-1:0]]};
          req.last = (cnt_r == '0);
        end
      end
      MODE_INIT: begin
        req.data = init_byte(cnt_r[2:0]);
        req.last = (cnt_r == CNT_W'(INIT_LEN - 1));
      end
      default: ;
    endcase
  end

  clcd_nibble_tx u_tx (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_ready (req_ready),
    .out_chan  (out_chan)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cfg_pad_r <= 1'b1;
      pad_r     <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (cfg_chan.valid) cfg_pad_r <= cfg_chan.data;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            mode_r <= item.mode;
            byte_r <= item.value[7:0];
            cnt_r  <= '0;
            pad_r  <= cfg_pad_r && (item.value < VALUE_W'(10));
            unique case (item.mode)
              MODE_DATA, MODE_CMD, MODE_INIT: state_r <= S_EMIT;
              MODE_CURSOR: begin
                byte_r <= cursor_byte;
                if (cursor_ok) state_r <= S_EMIT;
              end
              MODE_INT: state_r <= S_CONV;
              default: ;
            endcase
          end
        end
        S_CONV: begin
          if (conv_done) begin
            cnt_r   <= CNT_W'(msd_idx);
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (req_ready) begin
            if (req.last) begin
              state_r <= S_IDLE;
            end else if (mode_r == MODE_INIT) begin
              cnt_r <= cnt_r + 1'b1;
            end else if (pad_r) begin
              pad_r <= 1'b0;
            end else begin
              cnt_r <= cnt_r - 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/clcd_checker.sv
// Checker: port-level assertions for the LCD nibble write engine, with its bind.
module clcd_checker
  import clcd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input clcd_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input clcd_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped during stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out payload changed during stall");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid after reset");

  a_busy_after_char: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.mode == MODE_DATA) |=> !in_ready)
    else $error("ready while a character is being sent");

  a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.mode > MODE_INIT) |=> in_ready)
    else $error("unused mode left the block busy");

endmodule

bind char_lcd_nibble_write_engine clcd_checker u_clcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_data   (in_chan.data),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

### bench/char_lcd_nibble_write_engine_tb.sv
`timescale 1ns / 100ps
// Testbench: checks the LCD nibble write engine against a built-in nibble predictor.
module char_lcd_nibble_write_engine_tb
  import clcd_pkg::*;
();

  localparam int LCD_ROWS       = 4;
  localparam int LCD_COLS       = 20;
  localparam int LCD_MAX_DIGITS = 10;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 70;
  localparam int QUIET_LIMIT    = 4000;
  localparam int RANDOM_ITEMS   = 140;

  localparam logic [6:0] ROW_OFFSET [LCD_ROWS] = '{7'h00, 7'h40, 7'h14, 7'h54};
  localparam logic [7:0] STARTUP_SEQ [7] = '{8'h03, 8'h03, 8'h02, 8'h28, 8'h01, 8'h0C, 8'h06};

  logic clk;
  logic rst_n;

  clcd_stream_if #(.payload_t(clcd_in_t))  in_if ();
  clcd_stream_if #(.payload_t(clcd_out_t)) out_if ();
  clcd_stream_if #(.payload_t(logic))      cfg_if ();

  char_lcd_nibble_write_engine #(
    .ROWS       (LCD_ROWS),
    .COLUMNS    (LCD_COLS),
    .MAX_DIGITS (LCD_MAX_DIGITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  clcd_out_t   expected_nibbles [$];
  logic        pad_enable;
  int unsigned mismatches;
  bit          idle_on;
  int unsigned hold_ticket;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void queue_byte(input logic rs, input logic [7:0] b);
    clcd_out_t n;
    n.reg_select = rs;
    n.last       = 1'b0;
    n.nibble     = b[7:4];
    expected_nibbles.push_back(n);
    n.nibble     = b[3:0];
    expected_nibbles.push_back(n);
  endfunction

  function automatic void predict_nibbles(input clcd_in_t req);
    int          start_len;
    int          nd;
    int          keep;
    logic [31:0] v;
    logic [3:0]  digits [INT_DIGITS];
    logic [6:0]  addr;
    clcd_out_t   tail;
    start_len = expected_nibbles.size();
    case (req.mode)
      MODE_DATA: queue_byte(1'b1, req.value[7:0]);
      MODE_CMD:  queue_byte(1'b0, req.value[7:0]);
      MODE_CURSOR: begin
        if (req.row < LCD_ROWS && req.column < LCD_COLS) begin
          addr = ROW_OFFSET[req.row[1:0]] + 7'(req.column);
          queue_byte(1'b0, CURSOR_CMD | {1'b0, addr});
        end
      end
      MODE_INT: begin
        v  = req.value;
        nd = 0;
        do begin
          digits[nd] = 4'(v % 10);
          v = v / 10;
          nd++;
        end while (v != 0 && nd < INT_DIGITS);
        keep = (nd < LCD_MAX_DIGITS) ? nd : LCD_MAX_DIGITS;
        if (pad_enable && req.value < 10) queue_byte(1'b1, ASCII_ZERO);
        for (int k = keep - 1; k >= 0; k--) queue_byte(1'b1, ASCII_ZERO + 8'(digits[k]));
      end
      MODE_INIT: begin
        for (int i = 0; i < 7; i++) queue_byte(1'b0, STARTUP_SEQ[i]);
      end
      default: ;
    endcase
    if (expected_nibbles.size() > start_len) begin
      tail = expected_nibbles.pop_back();
      tail.last = 1'b1;
      expected_nibbles.push_back(tail);
    end
  endfunction

  function automatic clcd_in_t make_req(input logic [2:0] mode, input logic [31:0] value,
                                        input logic [2:0] row, input logic [4:0] column);
    clcd_in_t r;
    r.mode   = mode;
    r.value  = value;
    r.row    = row;
    r.column = column;
    return r;
  endfunction

  function automatic clcd_in_t random_request();
    clcd_in_t r;
    int       pick;
    r.value  = $urandom();
    r.row    = 3'($urandom_range(0, 7));
    r.column = 5'($urandom_range(0, 31));
    pick     = $urandom_range(0, 99);
    if (pick < 20) begin
      r.mode = MODE_DATA;
    end else if (pick < 35) begin
      r.mode = MODE_CMD;
    end else if (pick < 55) begin
      r.mode = MODE_CURSOR;
      if ($urandom_range(0, 4) != 0) begin
        r.row    = 3'($urandom_range(0, LCD_ROWS - 1));
        r.column = 5'($urandom_range(0, LCD_COLS - 1));
      end
    end else if (pick < 85) begin
      r.mode = MODE_INT;
      case ($urandom_range(0, 3))
        0: r.value = $urandom_range(0, 12);
        1: r.value = $urandom_range(0, 99999);
        default: ;
      endcase
    end else if (pick < 93) begin
      r.mode = MODE_INIT;
    end else begin
      r.mode = MODE_INIT + 3'($urandom_range(1, 3));
    end
    return r;
  endfunction

  task automatic send_request(input clcd_in_t req);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= req;
    do @(posedge clk); while (!in_if.ready);
    predict_nibbles(req);
  endtask

  task automatic drain_outputs();
    in_if.valid <= 1'b0;
    while (expected_nibbles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pad(input logic pad);
    drain_outputs();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= pad;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    pad_enable = pad;
  endtask

  task automatic test_single_bytes();
    send_request(make_req(MODE_DATA, 32'h0000_0000, 3'd0, 5'd0));
    send_request(make_req(MODE_DATA, 32'hFFFF_FFFF, 3'd7, 5'd31));
    send_request(make_req(MODE_DATA, 32'hA5A5_A541, 3'd2, 5'd9));
    send_request(make_req(MODE_CMD, 32'hFFFF_FF00, 3'd0, 5'd0));
    send_request(make_req(MODE_CMD, 32'h0000_00FF, 3'd5, 5'd17));
  endtask

  task automatic test_cursor();
    send_request(make_req(MODE_CURSOR, 32'h0, 3'd0, 5'd0));
    send_request(make_req(MODE_CURSOR, 32'hFFFF_FFFF, 3'd3, 5'd19));
    send_request(make_req(MODE_CURSOR, 32'h0, 3'd1, 5'd0));
    send_request(make_req(MODE_CURSOR, 32'h0, 3'd2, 5'd19));
    // out of range: row, column, both
    send_request(make_req(MODE_CURSOR, 32'h0, 3'd4, 5'd0));
    send_request(make_req(MODE_CURSOR, 32'h0, 3'd0, 5'd20));
    send_request(make_req(MODE_CURSOR, 32'h0, 3'd7, 5'd31));
  endtask

  task automatic test_integers();
    send_request(make_req(MODE_INT, 32'd0, 3'd0, 5'd0));
    send_request(make_req(MODE_INT, 32'd9, 3'd0, 5'd0));
    send_request(make_req(MODE_INT, 32'd10, 3'd0, 5'd0));
    send_request(make_req(MODE_INT, 32'hFFFF_FFFF, 3'd0, 5'd0));
    send_request(make_req(MODE_INT, 32'd1000000000, 3'd0, 5'd0));
    write_pad(1'b0);
    send_request(make_req(MODE_INT, 32'd0, 3'd0, 5'd0));
    send_request(make_req(MODE_INT, 32'd7, 3'd0, 5'd0));
    send_request(make_req(MODE_INT, 32'd10, 3'd0, 5'd0));
    write_pad(1'b1);
  endtask

  task automatic test_init_and_unused();
    send_request(make_req(MODE_INIT, 32'h0, 3'd0, 5'd0));
    send_request(make_req(MODE_INIT + 3'd1, 32'hFFFF_FFFF, 3'd3, 5'd1));
    send_request(make_req(MODE_INIT + 3'd2, 32'h0, 3'd0, 5'd0));
    send_request(make_req(MODE_INIT + 3'd3, 32'h1234_5678, 3'd1, 5'd2));
    send_request(make_req(MODE_DATA, 32'h0000_0042, 3'd0, 5'd0));
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    hold_ticket++;
    send_request(make_req(MODE_INIT, 32'h0, 3'd0, 5'd0));
    send_request(make_req(MODE_INT, 32'hFFFF_FFFF, 3'd0, 5'd0));
    for (int i = 0; i < 6; i++) send_request(random_request());
  endtask

  task automatic test_random();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 40 || i == 80 || i == 120) write_pad(1'($urandom_range(0, 1)));
      if (i == RANDOM_ITEMS - 30) idle_on = 1'b0;
      send_request(random_request());
    end
  endtask

  initial begin : sink_pacing
    int unsigned hold_seen;
    int          hold_left;
    int          burst_left;
    hold_seen  = 0;
    hold_left  = 0;
    burst_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        hold_left = LONG_HOLD - 1;
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        burst_left = $urandom_range(1, 12) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_nibble
    clcd_out_t got;
    clcd_out_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_nibbles.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual rs=%0b nibble=%h last=%0b",
                 $time, got.reg_select, got.nibble, got.last);
        mismatches++;
      end else begin
        want = expected_nibbles.pop_front();
        if (got.reg_select !== want.reg_select) begin
          $display("%0t: reg_select mismatch: expected %0b, actual %0b",
                   $time, want.reg_select, got.reg_select);
          mismatches++;
        end
        if (got.nibble !== want.nibble) begin
          $display("%0t: nibble mismatch: expected %h, actual %h", $time, want.nibble, got.nibble);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
          || (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    mismatches   = 0;
    pad_enable   = 1'b1;
    idle_on      = 1'b1;
    hold_ticket  = 0;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_bytes();
    test_cursor();
    test_integers();
    test_init_and_unused();
    test_backpressure();
    test_random();

    drain_outputs();
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
